FILE: src/udpc_pkg.sv
// Package for the UDP receive checker: verdict codes, register indexes,
// and the datagram record passed from the parser to the classifier.
// No dependencies.
`default_nettype none

package udpc_pkg;

    typedef enum logic [2:0] {
        VERDICT_ACCEPT    = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_BAD_LEN   = 3'd2,
        VERDICT_BAD_CSUM  = 3'd3,
        VERDICT_NO_SOCKET = 3'd4
    } t_verdict;

    localparam logic [2:0] CFG_SLOT_ENABLE = 3'd4;
    localparam int         MAX_SLOTS       = 4;
    localparam int         QUEUE_DEPTH     = 4;
    localparam int         QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam logic [15:0] HDR_LEN        = 16'd8;
    localparam logic [15:0] PROTO_UDP      = 16'd17;

    typedef struct packed {
        logic [15:0] byte_cnt;
        logic [31:0] sum;
        logic [7:0]  hold;
        logic [15:0] len;
        logic [15:0] csum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] sip;
        logic [31:0] dip;
    } t_dgram;

    typedef struct packed {
        logic push;
        logic full;
    } t_q_wr;

    typedef struct packed {
        logic pop;
        logic valid;
    } t_q_rd;

endpackage

`default_nettype wire

FILE: src/udp_receive_checker_top.sv
// Top level of the UDP receive checker: port-binding registers and the
// parser, queue and classifier. Depends on udpc_pkg and the udpc_* modules.
//
// Datagram bytes are taken one per clock with no gaps required between
// datagrams; the parser holds the running checksum and header fields and hands
// a record to a four-entry queue on the last byte. The classifier takes one
// record per cycle, unless the output is stalled, through two stages
// (partial sums and port lookup, then final add, fold and verdict) into an
// output register; a record passes the queue and then the stage register.
// Only a last byte is stalled, and only while the queue is full. Drop counters
// clear at reset and reflect the update for the datagram being shown.
`default_nettype none

module udp_receive_checker_top
    import udpc_pkg::*;
#(
    parameter int PORT_SLOTS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [31:0] i_dest_ip,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_verdict,
    output logic [1:0]       o_socket_index,
    output logic [15:0]      o_source_port,
    output logic [15:0]      o_dest_port,
    output logic [15:0]      o_data_length,
    output logic             o_checksum_checked,
    output logic [31:0]      o_short_count,
    output logic [31:0]      o_bad_length_count,
    output logic [31:0]      o_bad_checksum_count,
    output logic [31:0]      o_no_socket_count,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int NSLOT = (PORT_SLOTS < MAX_SLOTS) ? PORT_SLOTS : MAX_SLOTS;

    logic [15:0]      r_port_slot [NSLOT];
    logic [NSLOT-1:0] r_slot_en;
    logic             cfg_wr;

    t_q_wr  q_wr;
    t_q_rd  q_rd;
    t_dgram q_in;
    t_dgram q_head;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    for (genvar k = 0; k < NSLOT; k++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_port_slot[k] <= '0;
            end else if (cfg_wr && i_cfg_index == 3'(k)) begin
                r_port_slot[k] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_en <= '0;
        end else if (cfg_wr && i_cfg_index == CFG_SLOT_ENABLE) begin
            r_slot_en <= i_cfg_data[NSLOT-1:0];
        end
    end

    udpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_source_ip (i_source_ip),
        .i_dest_ip   (i_dest_ip),
        .i_q_full    (q_wr.full),
        .o_q_push    (q_wr.push),
        .o_q_data    (q_in)
    );

    udpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_wr.push),
        .i_data  (q_in),
        .o_full  (q_wr.full),
        .i_pop   (q_rd.pop),
        .o_valid (q_rd.valid),
        .o_data  (q_head)
    );

    udpc_back #(
        .NSLOT (NSLOT)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_rd.valid),
        .i_q_data             (q_head),
        .o_q_pop              (q_rd.pop),
        .i_port_slot          (r_port_slot),
        .i_slot_en            (r_slot_en),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_verdict            (o_verdict),
        .o_socket_index       (o_socket_index),
        .o_source_port        (o_source_port),
        .o_dest_port          (o_dest_port),
        .o_data_length        (o_data_length),
        .o_checksum_checked   (o_checksum_checked),
        .o_short_count        (o_short_count),
        .o_bad_length_count   (o_bad_length_count),
        .o_bad_checksum_count (o_bad_checksum_count),
        .o_no_socket_count    (o_no_socket_count)
    );

endmodule

`default_nettype wire

FILE: src/udpc_front.sv
// Byte parser: captures header fields and accumulates the checksum sum.
// Pushes one datagram record per last byte. Depends on udpc_pkg.
`default_nettype none

module udpc_front
    import udpc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [31:0] i_dest_ip,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_dgram           o_q_data
);

    logic [15:0] r_byte_cnt, n_byte_cnt;
    logic [31:0] r_sum, n_sum;
    logic [7:0]  r_hold, n_hold;
    logic [15:0] r_len, n_len;
    logic [15:0] r_csum, n_csum;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic        accept;
    logic        in_range;

    assign o_in_stall = i_q_full && i_last;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_q_push   = accept && i_last;

    always_comb begin
        n_sport = r_sport;
        n_dport = r_dport;
        n_len   = r_len;
        n_csum  = r_csum;
        n_hold  = r_hold;
        n_sum   = r_sum;
        if (r_byte_cnt[15:3] == 13'd0) begin
            unique case (r_byte_cnt[2:0])
                3'd0:    n_sport = {i_data_byte, 8'h00};
                3'd1:    n_sport = {r_sport[15:8], i_data_byte};
                3'd2:    n_dport = {i_data_byte, 8'h00};
                3'd3:    n_dport = {r_dport[15:8], i_data_byte};
                3'd4:    n_len   = {i_data_byte, 8'h00};
                3'd5:    n_len   = {r_len[15:8], i_data_byte};
                3'd6:    n_csum  = {i_data_byte, 8'h00};
                default: n_csum  = {r_csum[15:8], i_data_byte};
            endcase
        end
        in_range = (r_byte_cnt < 16'd6) || (r_byte_cnt < n_len);
        if (in_range) begin
            if (!r_byte_cnt[0]) begin
                n_hold = i_data_byte;
            end else begin
                n_sum = r_sum + {16'd0, r_hold, i_data_byte};
            end
        end
        n_byte_cnt = (r_byte_cnt == 16'hFFFF) ? r_byte_cnt : r_byte_cnt + 16'd1;
    end

    always_comb begin
        o_q_data.byte_cnt = n_byte_cnt;
        o_q_data.sum      = n_sum;
        o_q_data.hold     = n_hold;
        o_q_data.len      = n_len;
        o_q_data.csum     = n_csum;
        o_q_data.sport    = n_sport;
        o_q_data.dport    = n_dport;
        o_q_data.sip      = i_source_ip;
        o_q_data.dip      = i_dest_ip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            r_byte_cnt <= '0;
            r_sum      <= '0;
            r_hold     <= '0;
            r_len      <= '0;
            r_csum     <= '0;
            r_sport    <= '0;
            r_dport    <= '0;
        end else if (accept) begin
            r_byte_cnt <= n_byte_cnt;
            r_sum      <= n_sum;
            r_hold     <= n_hold;
            r_len      <= n_len;
            r_csum     <= n_csum;
            r_sport    <= n_sport;
            r_dport    <= n_dport;
        end
    end

endmodule

`default_nettype wire

FILE: src/udpc_queue.sv
// Small FIFO of datagram records between parser and classifier.
// Depends on udpc_pkg.
`default_nettype none

module udpc_queue
    import udpc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  t_dgram      i_data,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_valid,
    output t_dgram      o_data
);

    t_dgram              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("queue pop while empty");

endmodule

`default_nettype wire

FILE: src/udpc_back.sv
// Classifier: length and checksum checks, port lookup, drop counters and
// the output register. Depends on udpc_pkg.
`default_nettype none

module udpc_back
    import udpc_pkg::*;
#(
    parameter int NSLOT = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  t_dgram                 i_q_data,
    output logic                   o_q_pop,
    input  wire logic [15:0]       i_port_slot [NSLOT],
    input  wire logic [NSLOT-1:0]  i_slot_en,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_verdict,
    output logic [1:0]             o_socket_index,
    output logic [15:0]            o_source_port,
    output logic [15:0]            o_dest_port,
    output logic [15:0]            o_data_length,
    output logic                   o_checksum_checked,
    output logic [31:0]            o_short_count,
    output logic [31:0]            o_bad_length_count,
    output logic [31:0]            o_bad_checksum_count,
    output logic [31:0]            o_no_socket_count
);

    typedef struct packed {
        logic        short_dg;
        logic        bad_len;
        logic        csum_nz;
        logic        found;
        logic [1:0]  sock;
        logic [31:0] p1;
        logic [31:0] p2;
        logic [15:0] len;
        logic [15:0] sport;
        logic [15:0] dport;
    } t_s1;

    t_s1         r_s1, n_s1;
    logic        r_s1_valid;
    logic        out_free;
    logic        load;

    logic [31:0] s_tot;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic        csum_ok;
    t_verdict    n_verdict;

    logic        r_out_valid;
    t_verdict    r_verdict;
    logic [1:0]  r_sock;
    logic [15:0] r_sport;
    logic [15:0] r_dport;
    logic [15:0] r_dlen;
    logic        r_checked;
    logic [31:0] r_cnt [4];

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = i_q_valid && (!r_s1_valid || out_free);
    assign load     = r_s1_valid && out_free;

    always_comb begin
        n_s1.short_dg = (i_q_data.byte_cnt < HDR_LEN);
        n_s1.bad_len  = (i_q_data.len < HDR_LEN) || (i_q_data.len > i_q_data.byte_cnt);
        n_s1.csum_nz  = (i_q_data.csum != 16'd0);
        n_s1.p1       = i_q_data.sum
                      + (i_q_data.len[0] ? {16'd0, i_q_data.hold, 8'h00} : 32'd0)
                      + {16'd0, i_q_data.sip[31:16]}
                      + {16'd0, i_q_data.sip[15:0]};
        n_s1.p2       = {16'd0, i_q_data.dip[31:16]}
                      + {16'd0, i_q_data.dip[15:0]}
                      + {16'd0, PROTO_UDP}
                      + {16'd0, i_q_data.len};
        n_s1.len      = i_q_data.len;
        n_s1.sport    = i_q_data.sport;
        n_s1.dport    = i_q_data.dport;
        n_s1.found    = 1'b0;
        n_s1.sock     = 2'd0;
        for (int k = NSLOT - 1; k >= 0; k--) begin
            if (i_slot_en[k] && (i_port_slot[k] == i_q_data.dport)) begin
                n_s1.found = 1'b1;
                n_s1.sock  = 2'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1 <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_s1_valid <= 1'b1;
        end else if (out_free) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_comb begin
        s_tot   = r_s1.p1 + r_s1.p2;
        fold1   = {1'b0, s_tot[15:0]} + {1'b0, s_tot[31:16]};
        fold2   = fold1[15:0] + {15'd0, fold1[16]};
        csum_ok = !r_s1.csum_nz || (fold2 == 16'hFFFF);
        if (r_s1.short_dg) begin
            n_verdict = VERDICT_SHORT;
        end else if (r_s1.bad_len) begin
            n_verdict = VERDICT_BAD_LEN;
        end else if (!csum_ok) begin
            n_verdict = VERDICT_BAD_CSUM;
        end else if (!r_s1.found) begin
            n_verdict = VERDICT_NO_SOCKET;
        end else begin
            n_verdict = VERDICT_ACCEPT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_verdict <= n_verdict;
            r_sock    <= (n_verdict == VERDICT_ACCEPT) ? r_s1.sock : 2'd0;
            r_sport   <= r_s1.short_dg ? 16'd0 : r_s1.sport;
            r_dport   <= r_s1.short_dg ? 16'd0 : r_s1.dport;
            r_dlen    <= (n_verdict == VERDICT_ACCEPT) ? r_s1.len - HDR_LEN : 16'd0;
            r_checked <= !r_s1.short_dg && !r_s1.bad_len && r_s1.csum_nz && csum_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_cnt[2]    <= '0;
            r_cnt[3]    <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
            if (load && n_verdict == VERDICT_SHORT) begin
                r_cnt[0] <= r_cnt[0] + 32'd1;
            end
            if (load && n_verdict == VERDICT_BAD_LEN) begin
                r_cnt[1] <= r_cnt[1] + 32'd1;
            end
            if (load && n_verdict == VERDICT_BAD_CSUM) begin
                r_cnt[2] <= r_cnt[2] + 32'd1;
            end
            if (load && n_verdict == VERDICT_NO_SOCKET) begin
                r_cnt[3] <= r_cnt[3] + 32'd1;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_verdict            = r_verdict;
    assign o_socket_index       = r_sock;
    assign o_source_port        = r_sport;
    assign o_dest_port          = r_dport;
    assign o_data_length        = r_dlen;
    assign o_checksum_checked   = r_checked;
    assign o_short_count        = r_cnt[0];
    assign o_bad_length_count   = r_cnt[1];
    assign o_bad_checksum_count = r_cnt[2];
    assign o_no_socket_count    = r_cnt[3];

    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && n_verdict == VERDICT_SHORT) |=> (r_cnt[0] == $past(r_cnt[0]) + 32'd1))
        else $error("short counter did not advance");

    a_drop_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != VERDICT_ACCEPT) |-> (r_dlen == 16'd0 && r_sock == 2'd0))
        else $error("dropped datagram carries length or socket");

    a_counters_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(load) |-> $stable(r_cnt[3]))
        else $error("no-socket counter moved without a result");

endmodule

`default_nettype wire
